### sv/bbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and constants of the chorus delay
// Payload structs, register indexes, mode codes, fixed-point gains, helpers.
// ----------------------------------------------------------------------------
package bbd_pkg;

   // delay store depth, power of two
   localparam int DELAY_DEPTH      = 2048;
   // sine phase quantization, power of two
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_QUANT       = 24 - $clog2(SINE_TABLE_DEPTH);

   // odd polynomial coefficients of the quarter-wave sine
   localparam logic [31:0] SIN_A = 32'd1686629713;
   localparam logic [31:0] SIN_B = 32'd693598564;
   localparam logic [31:0] SIN_C = 32'd85569278;
   localparam logic [31:0] SIN_D = 32'd5026991;

   localparam logic signed [17:0] WET_GAIN   = 18'sd42598;
   localparam logic signed [17:0] DRY_GAIN   = 18'sd22938;
   localparam logic signed [17:0] NOISE_GAIN = 18'sd41943;

   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_INC  = 32'd1013904223;
   localparam logic [31:0] LCG_SEED = 32'h6D2B79F5;

   localparam logic [23:0] PHASE_B_RESET = 24'h800000;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] REG_EFFECT_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWPASS_COEFF = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LFO_A_STEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LFO_B_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_DELAY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_DELAY    = 3'd5;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_I    = 2'd1;
   localparam logic [1:0] MODE_II   = 2'd2;
   localparam logic [1:0] MODE_BOTH = 2'd3;

   localparam logic [15:0] COEFF_RESET  = 16'd1283;
   localparam logic [19:0] STEP_A_RESET = 20'd175;
   localparam logic [19:0] STEP_B_RESET = 20'd308;
   localparam logic [16:0] DEPTH_RESET  = 17'd22118;
   localparam logic [17:0] BASE_RESET   = 18'd39322;

   typedef struct packed {
      logic signed [23:0] left_in;
      logic signed [23:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [23:0] left_out;
      logic signed [23:0] right_out;
   } rsp_type;

   // operands of one interpolation and output mix
   typedef struct packed {
      logic signed [23:0] y0;
      logic signed [23:0] y1;
      logic signed [23:0] y2;
      logic signed [23:0] y3;
      logic [7:0]         frac;
      logic signed [23:0] dry;
      logic signed [25:0] sub;
   } herm_in_type;

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] r;
      if (v > 64'sd8388607) r = 24'sd8388607;
      else if (v < -64'sd8388608) r = -24'sd8388608;
      else r = v[23:0];
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/bbd_chorus_delay_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_chorus_delay_top: stereo chorus on one modulated delay line
// Lowpass crossover, LFO and noise modulation, Hermite-interpolated reads.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_data  (left_in, right_in)
//  rsp      out        rsp_valid/rsp_ready    rsp_data  (left_out, right_out)
//  csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// In an active item the eight interpolation taps are read one per cycle from
// the single read port of the delay RAM, then the Hermite and mix pipeline
// settles. With the effect off an item skips the taps and the mix. After reset
// the delay RAM is cleared, one entry a cycle, with req_ready low. A result
// waits in an output register; a stalled rsp holds the next finished item in
// its last step until the register frees.
// ----------------------------------------------------------------------------
module bbd_chorus_delay_top #(
   parameter int DELAY_DEPTH = bbd_pkg::DELAY_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire bbd_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bbd_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bbd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW = $clog2(DELAY_DEPTH);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   localparam logic [4:0] K_LP    = 5'd0;
   localparam logic [4:0] K_LEVEL = 5'd1;
   localparam logic [4:0] K_WRITE = 5'd2;
   localparam logic [4:0] K_DELAY = 5'd4;
   localparam logic [4:0] K_POS   = 5'd5;
   localparam logic [4:0] K_RD0   = 5'd6;
   localparam logic [4:0] K_RDN   = 5'd13;
   localparam logic [4:0] K_DONE  = 5'd21;

   // configuration
   logic [1:0]  mode_ff;
   logic [15:0] coeff_ff;
   logic [19:0] step_a_ff, step_b_ff;
   logic [16:0] depth_ff;
   logic [17:0] base_ff;

   // control
   logic [1:0]    state_ff;
   logic [4:0]    step_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          pass_ff;
   logic          rd_pend_ff;
   logic [2:0]    rd_tag_ff;
   logic          rsp_valid_ff;

   // item and state
   logic signed [23:0] l_ff, r_ff;
   logic signed [25:0] level_ff;
   logic signed [24:0] noise_ff;
   logic [31:0]        seed_ff;
   logic [23:0]        phase_a_ff, phase_b_ff;
   logic [AW-1:0]      wp_ff;
   logic signed [43:0] lp_prod_ff, noise_prod_ff;
   logic signed [18:0] da_ff, db_ff;
   logic signed [8:0]  n_ff;
   logic [AW+7:0]      pos_l_ff, pos_r_ff;
   logic signed [23:0] y_ff [8];
   bbd_pkg::rsp_type   rsp_data_ff;

   logic signed [24:0] mono;
   logic signed [26:0] lp_diff;
   logic signed [24:0] white;
   logic signed [24:0] sine_a, sine_b;
   logic signed [45:0] da_full, db_full;
   logic signed [18:0] da_sel;
   logic signed [31:0] d_l, d_r, p_l, p_r;
   logic [2:0]         rd_j;
   logic [AW-1:0]      rd_base;
   logic [AW-1:0]      rd_addr;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [23:0]        ram_wdata;
   logic [23:0]        ram_rdata;
   logic               in_rd_window;
   logic               out_free;
   bbd_pkg::herm_in_type herm_l, herm_r;
   logic signed [23:0] wet_out_l, wet_out_r;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign mono    = 25'((26'(l_ff) + 26'(r_ff)) >>> 1);
   assign lp_diff = 27'(mono) - 27'(level_ff);
   assign white   = $signed({1'b0, seed_ff[31:8]}) - 25'sd8388608;

   assign da_full = 46'($signed({1'b0, depth_ff})) * 46'(26'sd8388608 + 26'(sine_a))
                    + 46'sd8388608;
   assign db_full = 46'($signed({1'b0, depth_ff})) * 46'(26'sd8388608 + 26'(sine_b))
                    + 46'sd8388608;
   assign da_sel  = (mode_ff == bbd_pkg::MODE_II) ? 19'(db_full >>> 24)
                                                   : 19'(da_full >>> 24);

   assign d_l = 32'($signed({1'b0, base_ff})) + 32'(da_ff) + 32'(n_ff);
   assign d_r = (mode_ff == bbd_pkg::MODE_BOTH)
                ? 32'($signed({1'b0, base_ff})) + 32'(db_ff) - 32'(n_ff)
                : 32'($signed({1'b0, base_ff})) - 32'(da_ff) - 32'(n_ff);
   assign p_l = $signed({{(24 - AW){1'b0}}, wp_ff, 8'd0}) - d_l;
   assign p_r = $signed({{(24 - AW){1'b0}}, wp_ff, 8'd0}) - d_r;

   // tap j: channel in bit 2, tap offset -1..+2 in bits 1:0
   assign rd_j         = 3'(step_ff - K_RD0);
   assign in_rd_window = (state_ff == ST_RUN) && (step_ff >= K_RD0) && (step_ff <= K_RDN);
   assign rd_base      = rd_j[2] ? pos_r_ff[AW+7:8] : pos_l_ff[AW+7:8];
   assign rd_addr      = rd_base + AW'(rd_j[1:0]) - AW'(1);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = (state_ff == ST_RUN) && (step_ff == K_WRITE);
         ram_waddr = wp_ff;
         ram_wdata = bbd_pkg::sat24(64'(27'(mono) - 27'(level_ff)));
      end
   end

   assign herm_l = '{y0: y_ff[0], y1: y_ff[1], y2: y_ff[2], y3: y_ff[3],
                     frac: pos_l_ff[7:0], dry: l_ff, sub: level_ff};
   assign herm_r = '{y0: y_ff[4], y1: y_ff[5], y2: y_ff[6], y3: y_ff[7],
                     frac: pos_r_ff[7:0], dry: r_ff, sub: level_ff};

   bbd_ram #(.WIDTH(24), .DEPTH(DELAY_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   bbd_sine u_sine_a (.clock(clock), .phase(phase_a_ff), .sine(sine_a));
   bbd_sine u_sine_b (.clock(clock), .phase(phase_b_ff), .sine(sine_b));

   bbd_hermite u_herm_l (.clock(clock), .hin(herm_l), .result(wet_out_l));
   bbd_hermite u_herm_r (.clock(clock), .hin(herm_r), .result(wet_out_r));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bbd_pkg::MODE_OFF;
         coeff_ff  <= bbd_pkg::COEFF_RESET;
         step_a_ff <= bbd_pkg::STEP_A_RESET;
         step_b_ff <= bbd_pkg::STEP_B_RESET;
         depth_ff  <= bbd_pkg::DEPTH_RESET;
         base_ff   <= bbd_pkg::BASE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            bbd_pkg::REG_EFFECT_MODE:   mode_ff   <= csr_data[1:0];
            bbd_pkg::REG_LOWPASS_COEFF: coeff_ff  <= csr_data[15:0];
            bbd_pkg::REG_LFO_A_STEP:    step_a_ff <= csr_data;
            bbd_pkg::REG_LFO_B_STEP:    step_b_ff <= csr_data;
            bbd_pkg::REG_DEPTH_DELAY:   depth_ff  <= csr_data[16:0];
            bbd_pkg::REG_BASE_DELAY:    base_ff   <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   // sequencer and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         clr_cnt_ff   <= '0;
         pass_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rd_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         noise_ff     <= '0;
         seed_ff      <= bbd_pkg::LCG_SEED;
         phase_a_ff   <= '0;
         phase_b_ff   <= bbd_pkg::PHASE_B_RESET;
         wp_ff        <= '0;
      end else begin
         // a new result may replace one leaving in the same cycle
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_pend_ff <= in_rd_window;
         rd_tag_ff  <= rd_j;

         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (clr_cnt_ff == AW'(DELAY_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  pass_ff  <= (mode_ff == bbd_pkg::MODE_OFF);
                  step_ff  <= '0;
                  state_ff <= (mode_ff == bbd_pkg::MODE_OFF) ? ST_OUT : ST_RUN;
               end
            end
            ST_RUN: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == K_LP) begin
                  seed_ff <= seed_ff * bbd_pkg::LCG_MUL + bbd_pkg::LCG_INC;
               end
               if (step_ff == K_LEVEL) begin
                  level_ff <= level_ff + 26'((lp_prod_ff + 44'sd32768) >>> 16);
               end
               if (step_ff == K_WRITE) begin
                  noise_ff <= noise_ff + 25'((noise_prod_ff + 44'sd8388608) >>> 24);
               end
               if (step_ff == K_DONE) begin
                  phase_a_ff <= phase_a_ff + 24'(step_a_ff);
                  phase_b_ff <= phase_b_ff + 24'(step_b_ff);
                  wp_ff      <= wp_ff + AW'(1);
                  state_ff   <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         l_ff <= req_data.left_in;
         r_ff <= req_data.right_in;
      end
      lp_prod_ff    <= 44'($signed({1'b0, coeff_ff})) * 44'(lp_diff);
      noise_prod_ff <= 44'(26'(white) - 26'(noise_ff)) * 44'(bbd_pkg::NOISE_GAIN);
      if (step_ff == K_DELAY) begin
         da_ff <= da_sel;
         db_ff <= 19'(db_full >>> 24);
         n_ff  <= 9'((noise_ff + 25'sd65536) >>> 17);
      end
      if (step_ff == K_POS) begin
         pos_l_ff <= p_l[AW+7:0];
         pos_r_ff <= p_r[AW+7:0];
      end
      if (rd_pend_ff) begin
         y_ff[rd_tag_ff] <= $signed(ram_rdata);
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff.left_out  <= pass_ff ? l_ff : wet_out_l;
         rsp_data_ff.right_out <= pass_ff ? r_ff : wet_out_r;
      end
   end

endmodule
`default_nettype wire

### sv/bbd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = bbd_pkg::DELAY_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/bbd_sine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_sine: quantized-phase sine, Q1.23
// Five-stage pipeline evaluating an odd polynomial over one quarter wave.
// ----------------------------------------------------------------------------
module bbd_sine (
   input  wire logic               clock,
   input  wire logic [23:0]        phase,
   output logic signed [24:0]      sine
);

   localparam int QB = bbd_pkg::SINE_QUANT;

   logic [23:0] p;
   logic [21:0] r;
   logic [22:0] x;
   logic [30:0] u;
   logic [30:0] u2;
   logic [23:0] mag;

   logic [60:0] uu_ff;
   logic [30:0] u_ff;
   logic        neg_ff;
   logic [31:0] t1_ff, t2_ff, t3_ff;
   logic signed [24:0] sine_ff;

   assign p  = {phase[23:QB], QB'(0)};
   assign r  = p[21:0];
   assign x  = p[22] ? (23'h400000 - {1'b0, r}) : {1'b0, r};
   assign u  = {x, 8'd0};
   assign u2 = uu_ff[60:30];
   assign mag = 24'((64'(t3_ff) * 64'(u_ff)) >> 37);

   always_ff @(posedge clock) begin
      uu_ff   <= 61'(62'(u) * 62'(u));
      u_ff    <= u;
      neg_ff  <= p[23];
      t1_ff   <= bbd_pkg::SIN_C - 32'((64'(bbd_pkg::SIN_D) * 64'(u2)) >> 30);
      t2_ff   <= bbd_pkg::SIN_B - 32'((64'(t1_ff) * 64'(u2)) >> 30);
      t3_ff   <= bbd_pkg::SIN_A - 32'((64'(t2_ff) * 64'(u2)) >> 30);
      sine_ff <= neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   assign sine = sine_ff;

endmodule
`default_nettype wire

### sv/bbd_hermite.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_hermite: cubic Hermite tap interpolation and wet/dry/sub mix
// Five-stage pipeline.
// ----------------------------------------------------------------------------
module bbd_hermite (
   input  wire logic                 clock,
   input  wire bbd_pkg::herm_in_type hin,
   output logic signed [23:0]        result
);

   logic signed [27:0] e0, e1, e2, e3;
   logic signed [8:0]  fs;
   logic signed [59:0] m3;
   logic signed [51:0] acc;
   logic signed [51:0] mix;

   logic signed [27:0] c1_ff, c2_ff, c3_ff;
   logic signed [39:0] m1_ff;
   logic signed [49:0] m2_ff;
   logic signed [31:0] wet_ff;
   logic signed [23:0] result_ff;

   assign e0 = 28'(hin.y0);
   assign e1 = 28'(hin.y1);
   assign e2 = 28'(hin.y2);
   assign e3 = 28'(hin.y3);
   assign fs = $signed({1'b0, hin.frac});

   assign m3  = 60'(m2_ff) * 60'(fs);
   assign acc = 52'(wet_ff) * 52'(bbd_pkg::WET_GAIN) + 52'(hin.dry) * 52'(bbd_pkg::DRY_GAIN)
                + 52'sd32768;
   assign mix = 52'(hin.sub) + (acc >>> 16);

   always_ff @(posedge clock) begin
      c1_ff <= e2 - e0;
      c2_ff <= e0 + e0 - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c3_ff <= e3 - e0 + e1 + e1 + e1 - e2 - e2 - e2;
      m1_ff <= 40'(c3_ff) * 40'(fs) + (40'(c2_ff) <<< 8);
      m2_ff <= 50'(m1_ff) * 50'(fs) + (50'(c1_ff) <<< 16);
      wet_ff <= 32'(hin.y1) + 32'((m3 + 60'sd16777216) >>> 25);
      result_ff <= bbd_pkg::sat24(64'(mix));
   end

   assign result = result_ff;

endmodule
`default_nettype wire

### verif/bbd_chorus_delay_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_chorus_delay_top_test: self-checking bench for the chorus delay
// A scoreboard class keeps its own copy of the delay line, LFO, noise and
// crossover state and computes each expected output pair. Directed items hit
// full-scale inputs and every mode; random phases reprogram the registers.
// ----------------------------------------------------------------------------
module bbd_chorus_delay_top_test;

   typedef logic [bbd_pkg::CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [bbd_pkg::CSR_DATA_W-1:0] csr_word_type;

   class chorus_scoreboard;
      int                errors;
      bbd_pkg::rsp_type  pending[$];
      longint            line_mem[bbd_pkg::DELAY_DEPTH];
      int                wr_ptr;
      logic [23:0]       phase_a, phase_b;
      longint            noise_lvl, low_lvl;
      logic [31:0]       seed;
      logic [1:0]        mode;
      longint            coeff, step_a, step_b, depth, base;

      function void reset_state();
         foreach (line_mem[i]) line_mem[i] = 0;
         wr_ptr = 0;
         phase_a = 24'd0;
         phase_b = bbd_pkg::PHASE_B_RESET;
         noise_lvl = 0;
         low_lvl = 0;
         seed = bbd_pkg::LCG_SEED;
         mode = bbd_pkg::MODE_OFF;
         coeff = bbd_pkg::COEFF_RESET;
         step_a = bbd_pkg::STEP_A_RESET;
         step_b = bbd_pkg::STEP_B_RESET;
         depth = bbd_pkg::DEPTH_RESET;
         base = bbd_pkg::BASE_RESET;
      endfunction

      function void write_reg(csr_idx_type idx, csr_word_type val);
         case (idx)
            bbd_pkg::REG_EFFECT_MODE:   mode = val[1:0];
            bbd_pkg::REG_LOWPASS_COEFF: coeff = val[15:0];
            bbd_pkg::REG_LFO_A_STEP:    step_a = val[19:0];
            bbd_pkg::REG_LFO_B_STEP:    step_b = val[19:0];
            bbd_pkg::REG_DEPTH_DELAY:   depth = val[16:0];
            bbd_pkg::REG_BASE_DELAY:    base = val[17:0];
            default: ;
         endcase
      endfunction

      function logic signed [23:0] clamp24(longint v);
         if (v > 8388607) return 24'sd8388607;
         if (v < -8388608) return -24'sd8388608;
         return v[23:0];
      endfunction

      // quarter-wave odd polynomial on a table-quantized phase
      function longint sine_at(logic [23:0] ph);
         longint unsigned idx, p, r, x, u, u2, t;
         longint unsigned q;
         longint s;
         idx = ({40'd0, ph} * bbd_pkg::SINE_TABLE_DEPTH) >> 24;
         p = (idx << 24) / bbd_pkg::SINE_TABLE_DEPTH;
         q = (p >> 22) & 3;
         r = p & 64'h3FFFFF;
         x = q[0] ? 64'h400000 - r : r;
         u = x << 8;
         u2 = (u * u) >> 30;
         t = bbd_pkg::SIN_D;
         t = bbd_pkg::SIN_C - ((t * u2) >> 30);
         t = bbd_pkg::SIN_B - ((t * u2) >> 30);
         t = bbd_pkg::SIN_A - ((t * u2) >> 30);
         s = longint'(((t * u) >> 30) >> 7);
         return (q >= 2) ? -s : s;
      endfunction

      function longint swing(longint s);
         return (depth * (8388608 + s) + 8388608) >>> 24;
      endfunction

      function longint hermite_read(longint d);
         longint m, pos, f, y0, y1, y2, y3, c1, c2, c3, acc;
         int i1;
         m = longint'(bbd_pkg::DELAY_DEPTH) * 256;
         pos = (longint'(wr_ptr) * 256 - d) % m;
         if (pos < 0) pos += m;
         i1 = int'(pos >> 8);
         f = pos & 255;
         y0 = line_mem[(i1 + bbd_pkg::DELAY_DEPTH - 1) % bbd_pkg::DELAY_DEPTH];
         y1 = line_mem[i1 % bbd_pkg::DELAY_DEPTH];
         y2 = line_mem[(i1 + 1) % bbd_pkg::DELAY_DEPTH];
         y3 = line_mem[(i1 + 2) % bbd_pkg::DELAY_DEPTH];
         c1 = y2 - y0;
         c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
         c3 = y3 - y0 + 3 * (y1 - y2);
         acc = ((c3 * f + c2 * 256) * f + c1 * 65536) * f;
         return y1 + ((acc + 16777216) >>> 25);
      endfunction

      function bbd_pkg::rsp_type chorus_out(bbd_pkg::req_type it);
         bbd_pkg::rsp_type o;
         longint l, r, mono, sub, upper, white, sa, sb, da, db, n, dl, dr, wl, wr;
         l = longint'(it.left_in);
         r = longint'(it.right_in);
         if (mode == bbd_pkg::MODE_OFF) begin
            o.left_out = it.left_in;
            o.right_out = it.right_in;
            return o;
         end
         mono = (l + r) >>> 1;
         low_lvl += (coeff * (mono - low_lvl) + 32768) >>> 16;
         sub = low_lvl;
         upper = longint'(clamp24(mono - sub));
         seed = seed * bbd_pkg::LCG_MUL + bbd_pkg::LCG_INC;
         white = longint'({40'd0, seed[31:8]}) - 8388608;
         noise_lvl += ((white - noise_lvl) * 41943 + 8388608) >>> 24;
         sa = sine_at(phase_a);
         sb = sine_at(phase_b);
         phase_a = phase_a + step_a[23:0];
         phase_b = phase_b + step_b[23:0];
         line_mem[wr_ptr] = upper;
         da = swing(sa);
         db = swing(sb);
         if (mode == bbd_pkg::MODE_II) da = db;
         n = (noise_lvl + 65536) >>> 17;
         dl = base + da + n;
         dr = base + ((mode == bbd_pkg::MODE_BOTH) ? db : -da) - n;
         wl = hermite_read(dl);
         wr = hermite_read(dr);
         o.left_out = clamp24(sub + ((42598 * wl + 22938 * l + 32768) >>> 16));
         o.right_out = clamp24(sub + ((42598 * wr + 22938 * r + 32768) >>> 16));
         wr_ptr = (wr_ptr + 1) % bbd_pkg::DELAY_DEPTH;
         return o;
      endfunction

      function void note_input(bbd_pkg::req_type it);
         pending.push_back(chorus_out(it));
      endfunction

      function void check_output(bbd_pkg::rsp_type got);
         bbd_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected item: left_out %0d right_out %0d",
                   got.left_out, got.right_out);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, got.left_out);
            errors++;
         end
         if (got.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, got.right_out);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   bbd_pkg::req_type      req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   bbd_pkg::rsp_type      rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_idx_type           csr_index = '0;
   csr_word_type          csr_data = '0;

   chorus_scoreboard sb = new();
   bit  sender_gaps, receiver_gaps;
   bit  stall_armed;
   int  rsp_count;
   int  quiet_cycles;

   always #5 clock = ~clock;

   bbd_chorus_delay_top dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   function int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function logic signed [23:0] sample_val();
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0: begin
            case ($urandom_range(0, 3))
               0: return 24'sd8388607;
               1: return -24'sd8388608;
               2: return 24'sd0;
               default: return -24'sd1;
            endcase
         end
         1, 2: return $signed(24'($urandom_range(0, 2047))) - 24'sd1024;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic send_item(logic signed [23:0] l, logic signed [23:0] r);
      int g;
      g = sender_gaps ? gap_len() : 0;
      repeat (g) @(negedge clock);
      req_data.left_in = l;
      req_data.right_in = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_input(req_data);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic settle();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, csr_word_type val);
      @(negedge clock);
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // register value: extremes a quarter of the time
   function csr_word_type pick(int hi);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return csr_word_type'(hi);
         default: return csr_word_type'($urandom_range(0, hi));
      endcase
   endfunction

   // receiver: random stalls, one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_output(rsp_data);
         rsp_count++;
      end
   end

   initial begin
      int g;
      @(negedge clock);
      while (1) begin
         if (stall_armed && rsp_count >= 300) begin
            stall_armed = 1'b0;
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
         end
         g = receiver_gaps ? gap_len() : 0;
         rsp_ready = (g == 0);
         if (g != 0) repeat (g) @(negedge clock);
         else @(negedge clock);
      end
   end

   // watchdog: cycles with no item moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 6000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic signed [23:0] ext[4];
      ext = '{24'sd8388607, -24'sd8388608, 24'sd0, -24'sd1};
      sb.reset_state();
      sb.errors = 0;
      stall_armed = 1'b1;
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // passthrough with the effect off
      send_item(ext[0], ext[1]);
      send_item(ext[1], ext[0]);
      send_item(ext[3], ext[2]);

      // mode I at reset settings, full-scale steps drive the crossover hard
      settle();
      write_csr(bbd_pkg::REG_EFFECT_MODE, csr_word_type'(bbd_pkg::MODE_I));
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 2; j++) send_item(ext[i], ext[(i + j + 1) % 4]);
      send_item(ext[0], ext[0]);
      send_item(ext[1], ext[1]);

      // upper band saturation: fast lowpass, then opposite rail
      settle();
      write_csr(bbd_pkg::REG_LOWPASS_COEFF, 20'd65535);
      write_csr(bbd_pkg::REG_EFFECT_MODE, csr_word_type'(bbd_pkg::MODE_II));
      send_item(ext[0], ext[0]);
      send_item(ext[1], ext[1]);
      send_item(ext[0], ext[0]);

      // zero base delay reads ahead of the write pointer; maximum depth
      settle();
      write_csr(bbd_pkg::REG_LOWPASS_COEFF, 20'd0);
      write_csr(bbd_pkg::REG_BASE_DELAY, 20'd0);
      write_csr(bbd_pkg::REG_DEPTH_DELAY, 20'd131071);
      write_csr(bbd_pkg::REG_LFO_A_STEP, 20'hFFFFF);
      write_csr(bbd_pkg::REG_LFO_B_STEP, 20'd0);
      write_csr(bbd_pkg::REG_EFFECT_MODE, csr_word_type'(bbd_pkg::MODE_BOTH));
      send_item(ext[0], ext[1]);
      send_item(ext[1], ext[0]);
      send_item(ext[0], ext[0]);
      send_item(ext[3], ext[0]);

      settle();
      write_csr(bbd_pkg::REG_BASE_DELAY, 20'd262143);
      send_item(ext[1], ext[1]);
      send_item(ext[0], ext[3]);

      // random phases, registers reprogrammed between them
      for (int ph = 0; ph < 12; ph++) begin
         settle();
         write_csr(bbd_pkg::REG_LOWPASS_COEFF, pick(65535));
         write_csr(bbd_pkg::REG_LFO_A_STEP, pick(1048575));
         write_csr(bbd_pkg::REG_LFO_B_STEP, pick(1048575));
         write_csr(bbd_pkg::REG_DEPTH_DELAY, pick(131071));
         write_csr(bbd_pkg::REG_BASE_DELAY, pick(262143));
         write_csr(bbd_pkg::REG_EFFECT_MODE,
                   (ph < 2) ? csr_word_type'(bbd_pkg::MODE_I) : pick(3));
         sender_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
         receiver_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
         for (int k = 0; k < 100; k++) send_item(sample_val(), sample_val());
      end

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
